// File: sv/rwg_pkg.sv
// ----------------------------------------------------------------------------
// rwg_pkg: shared types and constants for the rectangle weight grid
// Field widths, opcodes, register indexes and default grid limits.
// ----------------------------------------------------------------------------
package rwg_pkg;

	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_ROWS    = 64;

	localparam int OP_W    = 2;
	localparam int COORD_W = 7;
	localparam int CELL_W  = 8;
	localparam int SUM_W   = 20;
	localparam int CFG_IDX_W = 1;

	typedef logic [OP_W-1:0]    opcode_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [CELL_W-1:0]  cell_t;

	localparam opcode_t OP_ADD    = 2'd0;
	localparam opcode_t OP_REMOVE = 2'd1;
	localparam opcode_t OP_SUM    = 2'd2;
	localparam opcode_t OP_NONE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

endpackage

// File: sv/rwg_if.sv
// ----------------------------------------------------------------------------
// rwg_if: valid/ready channels of the rectangle weight grid
// Command channel (opcode and rectangle) and result channel.
// ----------------------------------------------------------------------------
interface rwg_in_if
	import rwg_pkg::*;
();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	coord_t  rect_x;
	coord_t  rect_y;
	coord_t  rect_width;
	coord_t  rect_height;

	modport source (output valid, opcode, rect_x, rect_y, rect_width, rect_height,
		input ready);
	modport sink (input valid, opcode, rect_x, rect_y, rect_width, rect_height,
		output ready);
endinterface

interface rwg_out_if
	import rwg_pkg::*;
();
	logic valid;
	logic ready;
	sum_t region_sum;
	logic out_of_bounds;

	modport source (output valid, region_sum, out_of_bounds, input ready);
	modport sink (input valid, region_sum, out_of_bounds, output ready);
endinterface

// File: sv/rwg_ram.sv
// ----------------------------------------------------------------------------
// rwg_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rwg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/rect_weight_grid_top.sv
// ----------------------------------------------------------------------------
// rect_weight_grid_top: 2D grid of 8-bit occupancy counters
// Add / remove / sum over a rectangle, one read-modify-write per cell for add and remove.
// ----------------------------------------------------------------------------
// Each covered cell takes a RAM read (S_READ) and, for add and remove, a write
//   (S_MOD); empty, rejected or unused commands go straight to S_DONE.
// Throughput: one command at a time; ready only while the sequencer is idle.
// Reset: grid size 0; a clearing pass over all MAX_COLUMNS*MAX_ROWS cells follows
//   reset and every size register write, with no command taken meanwhile.
module rect_weight_grid_top
	import rwg_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rwg_in_if.sink               in_ch,
	rwg_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata
);

	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int CALC_W     = (AW > 2 * COORD_W) ? AW : 2 * COORD_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
	localparam coord_t COL_LIMIT = (MAX_COLUMNS > 127) ? 7'd127 : COORD_W'(MAX_COLUMNS);
	localparam coord_t ROW_LIMIT = (MAX_ROWS > 127) ? 7'd127 : COORD_W'(MAX_ROWS);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_addr_q;
	coord_t        gw_q, gh_q;
	opcode_t       op_q;
	coord_t        col_q, col_start_q, col_end_q;
	coord_t        row_q, row_end_q;
	logic [CALC_W-1:0] row_base_q;
	sum_t          sum_q;
	logic          oob_q;
	logic          out_valid_q;
	sum_t          out_sum_q;
	logic          out_oob_q;

	logic          take;
	logic          in_bounds;
	logic [2*COORD_W-1:0] y_base;
	logic [CALC_W-1:0]    cell_full;
	logic [AW-1:0] cell_addr;
	logic [AW-1:0] ram_waddr;
	cell_t         ram_wdata;
	cell_t         ram_rdata;
	logic          ram_we;
	logic          col_last, row_last;
	logic          out_load;
	coord_t        cfg_clamped_w, cfg_clamped_h;

	assign in_ch.ready = (state_q == S_IDLE);
	assign take        = in_ch.valid && in_ch.ready;

	assign in_bounds = (gw_q != '0) && (gh_q != '0) &&
		({1'b0, in_ch.rect_x} + {1'b0, in_ch.rect_width} <= {1'b0, gw_q}) &&
		({1'b0, in_ch.rect_y} + {1'b0, in_ch.rect_height} <= {1'b0, gh_q});

	assign y_base    = in_ch.rect_y * gw_q;
	assign cell_full = row_base_q + CALC_W'(col_q);
	assign cell_addr = cell_full[AW-1:0];

	assign col_last = ({1'b0, col_q} + 8'd1) == {1'b0, col_end_q};
	assign row_last = ({1'b0, row_q} + 8'd1) == {1'b0, row_end_q};

	assign cfg_clamped_w = (cfg_wdata > COL_LIMIT) ? COL_LIMIT : cfg_wdata;
	assign cfg_clamped_h = (cfg_wdata > ROW_LIMIT) ? ROW_LIMIT : cfg_wdata;

	// Write side: zero during clearing, +/-1 on the cell read last cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr;
		ram_wdata = ram_rdata;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			S_MOD: begin
				ram_we    = (op_q == OP_ADD) || (op_q == OP_REMOVE);
				ram_wdata = (op_q == OP_ADD) ? ram_rdata + 8'd1 : ram_rdata - 8'd1;
			end
			default: ;
		endcase
	end

	rwg_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT),
		.AW   (AW)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cell_addr),
		.rdata(ram_rdata)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			gw_q       <= '0;
			gh_q       <= '0;
		end else if (cfg_we && (cfg_index == REG_GRID_WIDTH ||
				cfg_index == REG_GRID_HEIGHT)) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				gw_q <= cfg_clamped_w;
			end else begin
				gh_q <= cfg_clamped_h;
			end
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						if (in_ch.opcode == OP_NONE || !in_bounds ||
								in_ch.rect_width == '0 || in_ch.rect_height == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_MOD;
				S_MOD: begin
					if (col_last && row_last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Rectangle walk and accumulator (payload, no reset)
	always_ff @(posedge clk) begin
		if (take) begin
			op_q        <= in_ch.opcode;
			oob_q       <= (in_ch.opcode != OP_NONE) && !in_bounds;
			col_q       <= in_ch.rect_x;
			col_start_q <= in_ch.rect_x;
			col_end_q   <= in_ch.rect_x + in_ch.rect_width;
			row_q       <= in_ch.rect_y;
			row_end_q   <= in_ch.rect_y + in_ch.rect_height;
			row_base_q  <= CALC_W'(y_base);
			sum_q       <= '0;
		end else if (state_q == S_MOD) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
			if (col_last) begin
				col_q      <= col_start_q;
				row_q      <= row_q + 1'b1;
				row_base_q <= row_base_q + CALC_W'(gw_q);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sum_q <= (op_q == OP_SUM && !oob_q) ? sum_q : '0;
			out_oob_q <= oob_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.region_sum    = out_sum_q;
	assign out_ch.out_of_bounds = out_oob_q;

endmodule

// File: tb/rect_weight_grid_top_test.sv
// ----------------------------------------------------------------------------
// rect_weight_grid_top_test: self-checking bench for the rectangle weight grid
// A directed table covers the empty grid, size clipping, bounds, counter wrap
// and the unused opcode. Random phases follow with varied grid sizes. A copy of
// the counter grid is kept here, and every result transfer is checked in order.
// ----------------------------------------------------------------------------
module rect_weight_grid_top_test;
	import rwg_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_ITEMS = 225;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		opcode_t op;
		coord_t  x;
		coord_t  y;
		coord_t  w;
		coord_t  h;
	} rect_cmd_t;

	typedef struct packed {
		sum_t total;
		logic oob;
	} grid_result_t;

	typedef struct {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		coord_t               reg_val;
		rect_cmd_t            cmd;
		logic                 typed;
		grid_result_t         res;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_wdata;

	rwg_in_if  in_ch();
	rwg_out_if out_ch();

	rect_weight_grid_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// bench copy of the counter grid and its size
	cell_t        cell_mirror [DEF_MAX_ROWS][DEF_MAX_COLUMNS];
	int           mirror_cols;
	int           mirror_rows;
	grid_result_t pending_results [$];

	int   err_count     = 0;
	int   sent_count    = 0;
	int   checked_count = 0;
	int   oob_count     = 0;
	int   sum_count     = 0;
	int   cfg_count     = 0;
	int   cycle_count   = 0;
	int   stall_left    = 0;
	logic quiet         = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_mirror();
		foreach (cell_mirror[r, c])
			cell_mirror[r][c] = '0;
	endfunction

	function automatic void mirror_reg_write(logic [CFG_IDX_W-1:0] idx, coord_t val);
		int v;
		v = int'(val);
		if (idx == REG_GRID_WIDTH) begin
			mirror_cols = (v > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : v;
			clear_mirror();
		end else if (idx == REG_GRID_HEIGHT) begin
			mirror_rows = (v > DEF_MAX_ROWS) ? DEF_MAX_ROWS : v;
			clear_mirror();
		end
	endfunction

	// applies one command to the mirror and returns the result it should give
	function automatic grid_result_t run_rect_cmd(rect_cmd_t c);
		grid_result_t r;
		sum_t         acc;
		int           x_end;
		int           y_end;
		r     = '0;
		acc   = '0;
		x_end = int'(c.x) + int'(c.w);
		y_end = int'(c.y) + int'(c.h);
		if (c.op == OP_NONE)
			return r;
		if (mirror_cols == 0 || mirror_rows == 0 || x_end > mirror_cols ||
			y_end > mirror_rows) begin
			r.oob = 1'b1;
			return r;
		end
		for (int row = int'(c.y); row < y_end; row++) begin
			for (int col = int'(c.x); col < x_end; col++) begin
				case (c.op)
					OP_ADD: begin
						cell_mirror[row][col] = cell_t'(cell_mirror[row][col] + 1);
					end
					OP_REMOVE: begin
						cell_mirror[row][col] = cell_t'(cell_mirror[row][col] - 1);
					end
					OP_SUM: begin
						acc = sum_t'(acc + sum_t'(cell_mirror[row][col]));
					end
					default: ;
				endcase
			end
		end
		r.total = acc;
		return r;
	endfunction

	// mostly back-to-back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic rect_cmd_t random_cmd();
		rect_cmd_t c;
		int        p;
		int        wmax;
		int        hmax;
		p    = $urandom_range(0, 99);
		c.op = opcode_t'($urandom_range(0, 3));
		c.x  = coord_t'($urandom_range(0, 127));
		c.y  = coord_t'($urandom_range(0, 127));
		c.w  = coord_t'($urandom_range(0, 127));
		c.h  = coord_t'($urandom_range(0, 127));
		if (p < 4) begin
			c.op = OP_NONE;
			return c;
		end
		// raw fields: nearly always out of bounds
		if (p < 14 || mirror_cols == 0 || mirror_rows == 0)
			return c;
		p = $urandom_range(0, 9);
		if (p < 4)
			c.op = OP_ADD;
		else if (p < 6)
			c.op = OP_REMOVE;
		else
			c.op = OP_SUM;
		if ($urandom_range(0, 19) == 0) begin
			wmax = mirror_cols;
			hmax = mirror_rows;
		end else begin
			wmax = (mirror_cols < 8) ? mirror_cols : 8;
			hmax = (mirror_rows < 8) ? mirror_rows : 8;
		end
		c.w = coord_t'($urandom_range(0, wmax));
		c.h = coord_t'($urandom_range(0, hmax));
		c.x = coord_t'($urandom_range(0, mirror_cols - int'(c.w)));
		c.y = coord_t'($urandom_range(0, mirror_rows - int'(c.h)));
		return c;
	endfunction

	function automatic plan_row_t cmd_row(opcode_t op, int x, int y, int w, int h,
		logic typed = 1'b0, int total = 0, logic oob = 1'b0);
		plan_row_t row;
		row.is_cfg    = 1'b0;
		row.reg_idx   = '0;
		row.reg_val   = '0;
		row.cmd.op    = op;
		row.cmd.x     = coord_t'(x);
		row.cmd.y     = coord_t'(y);
		row.cmd.w     = coord_t'(w);
		row.cmd.h     = coord_t'(h);
		row.typed     = typed;
		row.res.total = sum_t'(total);
		row.res.oob   = oob;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
		plan_row_t row;
		row         = cmd_row(OP_NONE, 0, 0, 0, 0);
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = coord_t'(val);
		return row;
	endfunction

	function automatic void report_error(string what, int want, int got);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
	endfunction

	task automatic send_cmd(rect_cmd_t c, logic typed, grid_result_t typed_res);
		grid_result_t r;
		int           gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.opcode      <= c.op;
		in_ch.rect_x      <= c.x;
		in_ch.rect_y      <= c.y;
		in_ch.rect_width  <= c.w;
		in_ch.rect_height <= c.h;
		do
			@(posedge clk);
		while (!in_ch.ready);
		r = run_rect_cmd(c);
		pending_results.push_back(typed ? typed_res : r);
		sent_count++;
		if (r.oob)
			oob_count++;
		else if (c.op == OP_SUM)
			sum_count++;
	endtask

	task automatic wait_all_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_reg_write(idx, val);
		cfg_count++;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			stall_left   <= pick_gap();
			out_ch.ready <= 1'b1;
		end
	end

	// result check: each transfer against the oldest expectation
	always @(posedge clk) begin
		grid_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result: region_sum %0d, out_of_bounds %0d",
						$time, out_ch.region_sum, out_ch.out_of_bounds);
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (out_ch.region_sum !== want.total)
					report_error("region_sum", int'(want.total), int'(out_ch.region_sum));
				if (out_ch.out_of_bounds !== want.oob)
					report_error("out_of_bounds", int'(want.oob), int'(out_ch.out_of_bounds));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [$];
		int        cols_val;
		int        rows_val;
		int        n;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.opcode      = OP_ADD;
		in_ch.rect_x      = '0;
		in_ch.rect_y      = '0;
		in_ch.rect_width  = '0;
		in_ch.rect_height = '0;
		out_ch.ready      = 1'b0;
		mirror_cols       = 0;
		mirror_rows       = 0;
		clear_mirror();

		// grid is 0x0 after reset: add and sum are rejected as out of bounds
		plan.push_back(cmd_row(OP_ADD, 0, 0, 0, 0, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 1, 1, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_NONE, 127, 127, 127, 127, 1'b1, 0, 1'b0));
		// width above the limit is held at 64
		plan.push_back(cfg_row(REG_GRID_WIDTH, 127));
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 1));
		plan.push_back(cmd_row(OP_ADD, 0, 0, 64, 1, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 64, 1, 1'b1, 64, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 1, 0, 64, 1, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_REMOVE, 63, 0, 1, 1, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 64, 1, 1'b1, 63, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 64, 2, 1'b1, 0, 1'b1));
		// height write clears the store; counters wrap below zero
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 65));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 64, 64, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_REMOVE, 0, 0, 64, 64, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 64, 64, 1'b1, 1044480, 1'b0));
		plan.push_back(cmd_row(OP_ADD, 0, 0, 64, 64, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_ADD, 10, 20, 0, 5, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 64, 64, 0, 0, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 127, 0, 0, 0, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_ADD, 0, 127, 0, 0, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_REMOVE, 0, 0, 127, 1, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 1, 127, 1'b1, 0, 1'b1));
		plan.push_back(cmd_row(OP_ADD, 5, 7, 3, 2));
		plan.push_back(cmd_row(OP_ADD, 6, 7, 3, 3));
		plan.push_back(cmd_row(OP_SUM, 4, 6, 5, 4));
		plan.push_back(cmd_row(OP_NONE, 0, 0, 0, 0, 1'b1, 0, 1'b0));
		// zero height empties the grid again, then the 1x1 grid
		plan.push_back(cfg_row(REG_GRID_WIDTH, 1));
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 0));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 0, 0, 1'b1, 0, 1'b1));
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 1));
		plan.push_back(cmd_row(OP_ADD, 0, 0, 1, 1, 1'b1, 0, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 0, 0, 1, 1, 1'b1, 1, 1'b0));
		plan.push_back(cmd_row(OP_SUM, 1, 0, 0, 0, 1'b1, 0, 1'b0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_all_results();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_cmd(plan[i].cmd, plan[i].typed, plan[i].res);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					cols_val = 64;
					rows_val = 64;
				end
				1: begin
					cols_val = 1;
					rows_val = 64;
				end
				2: begin
					cols_val = 64;
					rows_val = 1;
				end
				3: begin
					cols_val = 0;
					rows_val = $urandom_range(0, 127);
				end
				4: begin
					cols_val = 127;
					rows_val = 127;
				end
				default: begin
					cols_val = $urandom_range(1, 127);
					rows_val = $urandom_range(1, 127);
				end
			endcase
			n = (cols_val == 0) ? 20 : PHASE_ITEMS;
			wait_all_results();
			quiet = (ph % 3 == 1);
			write_reg(REG_GRID_WIDTH, coord_t'(cols_val));
			write_reg(REG_GRID_HEIGHT, coord_t'(rows_val));
			repeat (n) begin
				// now and then hold off until the block has drained
				if ($urandom_range(0, 99) == 0)
					wait_all_results();
				send_cmd(random_cmd(), 1'b0, '0);
			end
		end

		wait_all_results();
		repeat (40) @(posedge clk);
		$display("Ran %0d commands across %0d register writes: %0d in-bounds sums, %0d rejected.",
			sent_count, cfg_count, sum_count, oob_count);
		$display("Compared %0d results, %0d errors found.", checked_count, err_count);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
